// ===== src/q2e_pkg.sv =====
// Shared constants, types and tables of the quaternion to Euler angle core.
`default_nettype none
package q2e_pkg;

	// pipeline geometry
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_TAB_LEN      = 24;
	localparam int ISQRT_STAGES      = 29;

	// datapath widths
	localparam int QW      = 16;   // quaternion component, Q1.14
	localparam int PW      = 32;   // product of two components
	localparam int SW      = 34;   // doubled sums, units 2^-28
	localparam int SSW     = 30;   // saturated sinX, signed
	localparam int RAD_W   = 57;   // 2^56 - sinX^2
	localparam int ROOT_W  = 29;   // integer square root of that
	localparam int SQRT_W  = 58;   // working width inside the root unit
	localparam int CIN_W   = 34;   // CORDIC operand width at entry
	localparam int CW      = 38;   // CORDIC working width
	localparam int ANG_W   = 34;   // CORDIC angle, units 2^-30 rad
	localparam int AW2     = 35;   // angle after doubling in gimbal lock
	localparam int OUT_W   = 25;   // Q8.16 output angle
	localparam int TOL_W   = 21;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic [29:0]             DEG_PER_RAD = 30'd961263669;
	localparam logic [TOL_W-1:0]        TOL_RESET   = 21'd2684;
	localparam logic signed [SW-1:0]    ONE_Q28     = 34'sd268435456;

	// register map, index taken from paddr[2]
	typedef enum logic {
		REG_DEGREES_MODE,
		REG_LOCK_TOL
	} reg_idx_t;

	// side data that travels beside the square root unit
	typedef struct packed {
		logic                   locked;
		logic                   neg;
		logic signed [SSW-1:0]  ss;
		logic signed [CIN_W-1:0] y_num;
		logic signed [CIN_W-1:0] y_den;
		logic signed [CIN_W-1:0] z_num;
		logic signed [CIN_W-1:0] z_den;
	} side_t;

	// flags that travel beside the CORDIC lanes
	typedef struct packed {
		logic locked;
		logic neg;
	} flag_t;

	// arctangent of 2^-k in units of 2^-30 rad
	function automatic logic signed [ANG_W-1:0] atan_entry(input int k);
		logic signed [ANG_W-1:0] v;
		case (k)
			0:  v = 34'sh03243F6A8;
			1:  v = 34'sh01DAC6705;
			2:  v = 34'sh00FADBAFC;
			3:  v = 34'sh007F56EA6;
			4:  v = 34'sh003FEAB76;
			5:  v = 34'sh001FFD55B;
			6:  v = 34'sh000FFFAAA;
			7:  v = 34'sh0007FFF55;
			8:  v = 34'sh0003FFFEA;
			9:  v = 34'sh0001FFFFD;
			10: v = 34'sh0000FFFFF;
			11: v = 34'sh00007FFFF;
			12: v = 34'sh00003FFFF;
			13: v = 34'sh00001FFFF;
			14: v = 34'sh00000FFFF;
			15: v = 34'sh000007FFF;
			16: v = 34'sh000003FFF;
			17: v = 34'sh000001FFF;
			18: v = 34'sh000000FFF;
			19: v = 34'sh0000007FF;
			20: v = 34'sh0000003FF;
			21: v = 34'sh0000001FF;
			22: v = 34'sh0000000FF;
			23: v = 34'sh00000007F;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== src/q2e_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module q2e_isqrt import q2e_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [RAD_W-1:0]  rad,
	output logic      [ROOT_W-1:0] root
);

	logic [SQRT_W-1:0] v_q [ISQRT_STAGES];
	logic [SQRT_W-1:0] r_q [ISQRT_STAGES];

	for (genvar k = 0; k < ISQRT_STAGES; k++) begin : g_stage
		localparam logic [SQRT_W-1:0] BITV = SQRT_W'(1) << (2 * (ISQRT_STAGES - 1 - k));
		logic [SQRT_W-1:0] v_in;
		logic [SQRT_W-1:0] r_in;
		logic [SQRT_W-1:0] trial;

		if (k == 0) begin : g_first
			assign v_in = SQRT_W'(rad);
			assign r_in = '0;
		end else begin : g_next
			assign v_in = v_q[k-1];
			assign r_in = r_q[k-1];
		end

		assign trial = r_in + BITV;

		// restoring step: keep the bit if the trial fits
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_in >= trial) begin
					v_q[k] <= v_in - trial;
					r_q[k] <= (r_in >> 1) + BITV;
				end else begin
					v_q[k] <= v_in;
					r_q[k] <= r_in >> 1;
				end
			end
		end
	end

	assign root = r_q[ISQRT_STAGES-1][ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== src/q2e_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(y, x) in units of 2^-30 rad.
`default_nettype none
module q2e_cordic import q2e_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [CIN_W-1:0] y_in,
	input  wire logic signed [CIN_W-1:0] x_in,
	output logic      signed [ANG_W-1:0] ang
);

	logic signed [CW-1:0]    x_q [STAGES+1];
	logic signed [CW-1:0]    y_q [STAGES+1];
	logic signed [ANG_W-1:0] a_q [STAGES+1];
	logic                    z_q [STAGES+1];

	// quadrant fold into the right half plane
	always_ff @(posedge clk) begin
		if (en) begin
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_q[0] <= CW'(y_in);
					y_q[0] <= -CW'(x_in);
					a_q[0] <= HALF_PI_Q30;
				end else begin
					x_q[0] <= -CW'(y_in);
					y_q[0] <= CW'(x_in);
					a_q[0] <= -HALF_PI_Q30;
				end
			end else begin
				x_q[0] <= CW'(x_in);
				y_q[0] <= CW'(y_in);
				a_q[0] <= '0;
			end
			z_q[0] <= (x_in == 0) && (y_in == 0);
		end
	end

	// micro-rotations, shifts round toward minus infinity
	for (genvar i = 1; i <= STAGES; i++) begin : g_iter
		localparam int SH = i - 1;
		localparam logic signed [ANG_W-1:0] ATAN = atan_entry(SH);
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;

		assign dx = y_q[i-1] >>> SH;
		assign dy = x_q[i-1] >>> SH;

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_q[i-1] > 0) begin
					x_q[i] <= x_q[i-1] + dx;
					y_q[i] <= y_q[i-1] - dy;
					a_q[i] <= a_q[i-1] + ATAN;
				end else begin
					x_q[i] <= x_q[i-1] - dx;
					y_q[i] <= y_q[i-1] + dy;
					a_q[i] <= a_q[i-1] - ATAN;
				end
				z_q[i] <= z_q[i-1];
			end
		end
	end

	// both operands zero give zero
	assign ang = z_q[STAGES] ? '0 : a_q[STAGES];

endmodule
`default_nettype wire

// ===== src/quaternion_to_euler_core.sv =====
// Quaternion to Euler angle core: products, lock test, square root, CORDIC, scaling.
// Throughput: one transaction per cycle; the whole pipe advances together and freezes
// while a finished result waits under angle_stall.
// The square root unit (29 stages) and the CORDIC chain set the depth.
// Reset clears the valid bits and the registers to radians and tolerance 2684.
`default_nettype none
module quaternion_to_euler_core import q2e_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration port
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [ADDR_W-1:0]       paddr,
	input  wire logic [DATA_W-1:0]       pwdata,
	output logic      [DATA_W-1:0]       prdata,
	output logic                         pready,
	// quaternion channel
	input  wire logic                    quat_valid,
	output logic                         quat_stall,
	input  wire logic signed [QW-1:0]    quat_w,
	input  wire logic signed [QW-1:0]    quat_x,
	input  wire logic signed [QW-1:0]    quat_y,
	input  wire logic signed [QW-1:0]    quat_z,
	// angle channel
	output logic                         angle_valid,
	input  wire logic                    angle_stall,
	output logic signed [OUT_W-1:0]      angle_x,
	output logic signed [OUT_W-1:0]      angle_y,
	output logic signed [OUT_W-1:0]      angle_z,
	output logic                         gimbal_locked
);

	localparam int LAT = 5 + ISQRT_STAGES + CORDIC_STAGES + 1 + 2;

	logic             deg_q;
	logic [TOL_W-1:0] tol_q;
	logic             vld_q [LAT];
	logic             en;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= 1'b0;
			tol_q <= TOL_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_DEGREES_MODE: deg_q <= pwdata[0];
				REG_LOCK_TOL:     tol_q <= pwdata[TOL_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DEGREES_MODE: prdata = {{(DATA_W-1){1'b0}}, deg_q};
			REG_LOCK_TOL:     prdata = {{(DATA_W-TOL_W){1'b0}}, tol_q};
			default:          prdata = '0;
		endcase
	end

	// global advance, held while the output register is full and stalled
	assign en          = !(vld_q[LAT-1] && angle_stall);
	assign quat_stall  = !en;
	assign angle_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= quat_valid;
			for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// stage 1: component products
	logic signed [PW-1:0] wx_s1, yz_s1, wy_s1, xz_s1, wz_s1, xy_s1, xx_s1, yy_s1, zz_s1;
	logic signed [QW-1:0] w_s1, y_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;
			wy_s1 <= quat_w * quat_y;
			xz_s1 <= quat_x * quat_z;
			wz_s1 <= quat_w * quat_z;
			xy_s1 <= quat_x * quat_y;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
			w_s1  <= quat_w;
			y_s1  <= quat_y;
		end
	end

	// stage 2: doubled sums, units 2^-28
	logic signed [SW-1:0] s_s2, yn_s2, yd_s2, zn_s2, zd_s2;
	logic signed [QW-1:0] w_s2, y_s2;
	logic signed [PW:0]   d_s, d_yn, d_zn, d_yd, d_zd;

	always_comb begin
		d_s  = (PW+1)'(wx_s1) - (PW+1)'(yz_s1);
		d_yn = (PW+1)'(wy_s1) + (PW+1)'(xz_s1);
		d_zn = (PW+1)'(wz_s1) + (PW+1)'(xy_s1);
		d_yd = (PW+1)'(xx_s1) + (PW+1)'(yy_s1);
		d_zd = (PW+1)'(xx_s1) + (PW+1)'(zz_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s2  <= {d_s, 1'b0};
			yn_s2 <= {d_yn, 1'b0};
			zn_s2 <= {d_zn, 1'b0};
			yd_s2 <= ONE_Q28 - $signed({d_yd, 1'b0});
			zd_s2 <= ONE_Q28 - $signed({d_zd, 1'b0});
			w_s2  <= w_s1;
			y_s2  <= y_s1;
		end
	end

	// stage 3: gimbal lock test, sinX saturation, operand choice for y
	side_t                side_s3;
	logic signed [SW-1:0] abs_s;
	logic signed [SW:0]   dev, abs_dev;
	logic                 locked;
	logic signed [SSW-1:0] ss;

	always_comb begin
		abs_s   = s_s2[SW-1] ? -s_s2 : s_s2;
		dev     = (SW+1)'(abs_s) - (SW+1)'(ONE_Q28);
		abs_dev = dev[SW] ? -dev : dev;
		locked  = abs_dev < $signed({{(SW+1-TOL_W){1'b0}}, tol_q});
		if (s_s2 > ONE_Q28)
			ss = SSW'(ONE_Q28);
		else if (s_s2 < -ONE_Q28)
			ss = -SSW'(ONE_Q28);
		else
			ss = SSW'(s_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.locked <= locked;
			side_s3.neg    <= s_s2[SW-1];
			side_s3.ss     <= ss;
			side_s3.y_num  <= locked ? CIN_W'($signed({y_s2, 14'b0})) : yn_s2;
			side_s3.y_den  <= locked ? CIN_W'($signed({w_s2, 14'b0})) : yd_s2;
			side_s3.z_num  <= zn_s2;
			side_s3.z_den  <= zd_s2;
		end
	end

	// stages 4 and 5: 2^56 - sinX^2
	side_t                 side_s4, side_s5;
	logic [RAD_W-1:0]      sq_s4, rad_s5;
	logic signed [2*SSW-1:0] sq_full;

	assign sq_full = side_s3.ss * side_s3.ss;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			sq_s4   <= sq_full[RAD_W-1:0];
			side_s5 <= side_s4;
			rad_s5  <= (RAD_W'(1) << 56) - sq_s4;
		end
	end

	// square root, side data delayed alongside
	logic [ROOT_W-1:0] root;
	side_t             side_d [ISQRT_STAGES];

	q2e_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s5),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s5;
			for (int i = 1; i < ISQRT_STAGES; i++) side_d[i] <= side_d[i-1];
		end
	end

	// three CORDIC lanes
	side_t                   side_c;
	logic signed [ANG_W-1:0] ax_c, ay_c, az_c;
	flag_t                   flg_q [CORDIC_STAGES+1];

	assign side_c = side_d[ISQRT_STAGES-1];

	q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_x (
		.clk  (clk),
		.en   (en),
		.y_in (CIN_W'(side_c.ss)),
		.x_in ($signed({{(CIN_W-ROOT_W){1'b0}}, root})),
		.ang  (ax_c)
	);

	q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_y (
		.clk  (clk),
		.en   (en),
		.y_in (side_c.y_num),
		.x_in (side_c.y_den),
		.ang  (ay_c)
	);

	q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_z (
		.clk  (clk),
		.en   (en),
		.y_in (side_c.z_num),
		.x_in (side_c.z_den),
		.ang  (az_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			flg_q[0].locked <= side_c.locked;
			flg_q[0].neg    <= side_c.neg;
			for (int i = 1; i <= CORDIC_STAGES; i++) flg_q[i] <= flg_q[i-1];
		end
	end

	// stage A: lock substitution and degree products
	flag_t                 flg_l;
	logic signed [AW2-1:0] sel [3];
	logic signed [AW2-1:0] a_s6 [3];
	logic signed [48:0]    phi_s6 [3];
	logic        [46:0]    plo_s6 [3];
	logic                  lock_s6;

	assign flg_l = flg_q[CORDIC_STAGES];

	always_comb begin
		if (flg_l.locked) begin
			sel[0] = flg_l.neg ? -AW2'(HALF_PI_Q30) : AW2'(HALF_PI_Q30);
			sel[1] = {ay_c, 1'b0};
			sel[2] = '0;
		end else begin
			sel[0] = AW2'(ax_c);
			sel[1] = AW2'(ay_c);
			sel[2] = AW2'(az_c);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				a_s6[l]   <= sel[l];
				phi_s6[l] <= $signed(sel[l][AW2-1:17]) * $signed({1'b0, DEG_PER_RAD});
				plo_s6[l] <= sel[l][16:0] * DEG_PER_RAD;
			end
			lock_s6 <= flg_l.locked;
		end
	end

	// stage B: round to Q8.16, saturating in degree mode
	logic signed [OUT_W-1:0] conv [3];
	logic signed [66:0]      dsum [3];
	logic signed [28:0]      dq   [3];
	logic signed [35:0]      rsum [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			dsum[l] = (67'(phi_s6[l]) <<< 17) + $signed(67'(plo_s6[l])) + (67'sd1 <<< 37);
			dq[l]   = dsum[l][66:38];
			rsum[l] = 36'(a_s6[l]) + 36'sd8192;
			if (deg_q) begin
				if (dq[l] > 29'sd16777215)
					conv[l] = 25'sd16777215;
				else if (dq[l] < -29'sd16777216)
					conv[l] = -25'sd16777216;
				else
					conv[l] = dq[l][OUT_W-1:0];
			end else begin
				conv[l] = OUT_W'($signed(rsum[l][35:14]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_x       <= conv[0];
			angle_y       <= conv[1];
			angle_z       <= conv[2];
			gimbal_locked <= lock_s6;
		end
	end

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the quaternion to Euler angle core.
`default_nettype none
module tb_top import q2e_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES  = 16;
	localparam int LATENCY = 37 + STAGES;
	localparam longint HALF_PI = 64'sd1686629713;
	localparam longint DEG_K   = 64'sd961263669;
	localparam longint ONE28   = 64'sd268435456;

	typedef struct packed {
		logic signed [QW-1:0] w, x, y, z;
	} quat_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] ax, ay, az;
		logic                    lk;
	} euler_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic quat_valid = 1'b0;
	logic quat_stall;
	logic signed [QW-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic angle_valid;
	logic angle_stall = 1'b0;
	logic signed [OUT_W-1:0] angle_x, angle_y, angle_z;
	logic gimbal_locked;

	quaternion_to_euler_core #(.CORDIC_STAGES(STAGES)) uut (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the registers
	logic               deg_mode = 1'b0;
	logic [TOL_W-1:0]   lock_tol = TOL_RESET;

	quat_t  pending_quats[$];
	euler_t expected_angles[$];
	int     mismatches = 0;
	bit     gaps_on = 1'b1;
	bit     hold_stream = 1'b0;

	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint root64(longint unsigned v);
		longint unsigned r = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// vectoring CORDIC, angle in 2^-30 rad
	function automatic longint vec_atan2(longint yv, longint xv);
		longint a = 0;
		longint t, dx, dy;
		if (xv == 0 && yv == 0) return 0;
		if (xv < 0) begin
			t = xv;
			if (yv >= 0) begin
				xv = yv; yv = -t; a = HALF_PI;
			end else begin
				xv = -yv; yv = t; a = -HALF_PI;
			end
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = floor_shr(yv, i);
			dy = floor_shr(xv, i);
			if (yv > 0) begin
				xv += dx; yv -= dy; a += longint'(atan_entry(i));
			end else begin
				xv -= dx; yv += dy; a -= longint'(atan_entry(i));
			end
		end
		return a;
	endfunction

	function automatic logic signed [OUT_W-1:0] scale_angle(longint a);
		longint v;
		if (deg_mode) v = floor_shr(a * DEG_K + (64'sd1 <<< 37), 38);
		else v = floor_shr(a + (64'sd1 <<< 13), 14);
		if (v > 16777215) v = 16777215;
		if (v < -16777216) v = -16777216;
		return v[OUT_W-1:0];
	endfunction

	function automatic euler_t predict_euler(quat_t q);
		longint w = q.w, x = q.x, y = q.y, z = q.z;
		longint s, dev, ss, c, ax, ay, az;
		euler_t e;
		s = 2 * (w * x - y * z);
		dev = (s < 0 ? -s : s) - ONE28;
		if (dev < 0) dev = -dev;
		e.lk = dev < longint'(lock_tol);
		if (e.lk) begin
			ax = (s < 0) ? -HALF_PI : HALF_PI;
			ay = 2 * vec_atan2(y * 16384, w * 16384);
			az = 0;
		end else begin
			ss = s;
			if (ss > ONE28) ss = ONE28;
			if (ss < -ONE28) ss = -ONE28;
			c = root64((64'd1 << 56) - longint'(ss * ss));
			ax = vec_atan2(ss, c);
			ay = vec_atan2(2 * (w * y + x * z), ONE28 - 2 * (x * x + y * y));
			az = vec_atan2(2 * (w * z + x * y), ONE28 - 2 * (x * x + z * z));
		end
		e.ax = scale_angle(ax);
		e.ay = scale_angle(ay);
		e.az = scale_angle(az);
		return e;
	endfunction

	// driver: one transaction per accepted handshake, random idle bursts
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (quat_valid && !quat_stall) begin
				expected_angles.push_back(predict_euler({quat_w, quat_x, quat_y, quat_z}));
			end
			if (!quat_valid || !quat_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					quat_valid <= 1'b0;
				end else if (gaps_on && $urandom_range(0, 15) == 0) begin
					send_gap <= $urandom_range(0, 9);
					quat_valid <= 1'b0;
				end else if (pending_quats.size() > 0 && !hold_stream) begin
					{quat_w, quat_x, quat_y, quat_z} <= pending_quats.pop_front();
					quat_valid <= 1'b1;
				end else begin
					quat_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare against the oldest expectation, stall at random
	int rcv_gap = 0;
	always @(posedge clk) begin
		euler_t got, want;
		if (arst_n) begin
			if (angle_valid && !angle_stall) begin
				got = {angle_x, angle_y, angle_z, gimbal_locked};
				if (expected_angles.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", got);
				end else begin
					want = expected_angles.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp %p got %p", want, got);
					end
				end
			end
			if (rcv_gap > 0) begin
				rcv_gap <= rcv_gap - 1;
				angle_stall <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 15) == 0) begin
				rcv_gap <= $urandom_range(0, 9);
				angle_stall <= 1'b1;
			end else begin
				angle_stall <= 1'b0;
			end
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_DEGREES_MODE) deg_mode = val[0];
		else lock_tol = val[TOL_W-1:0];
	endtask

	task automatic drain();
		while (pending_quats.size() > 0 || quat_valid || expected_angles.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic signed [QW-1:0] rnd_comp();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return QW'($urandom_range(0, 16384) - 8192);
			default: return QW'($urandom());
		endcase
	endfunction

	// unit quaternion from random angles, scaled to Q1.14
	function automatic quat_t rnd_unit();
		real a, b, c, n;
		quat_t q;
		a = ($urandom() % 100000) / 100000.0 * 6.2832;
		b = ($urandom() % 100000) / 100000.0 * 6.2832;
		c = ($urandom() % 100000) / 100000.0;
		n = $sqrt(c);
		q.w = QW'($rtoi($sin(a) * n * 16384.0));
		q.x = QW'($rtoi($cos(a) * n * 16384.0));
		q.y = QW'($rtoi($sin(b) * $sqrt(1.0 - c) * 16384.0));
		q.z = QW'($rtoi($cos(b) * $sqrt(1.0 - c) * 16384.0));
		return q;
	endfunction

	// gimbal lock candidates: x within one of w, sign at random, y=-z
	function automatic quat_t rnd_lock();
		quat_t q;
		int a = $urandom_range(0, 11585);
		int b = $urandom_range(0, 11585);
		q.w = QW'(a); q.x = QW'(a + int'($urandom_range(0, 2)) - 1);
		q.y = QW'(b); q.z = QW'(-b);
		if ($urandom_range(0, 1)) q.x = -q.x;
		return q;
	endfunction

	task automatic load_random(int n);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0, 1:    pending_quats.push_back(rnd_lock());
				2, 3:    pending_quats.push_back({rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp()});
				default: pending_quats.push_back(rnd_unit());
			endcase
		end
	endtask

	// stimulus
	initial begin
		quat_t q;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// directed: identity, zero, extremes, exact lock, near lock, saturation
		pending_quats.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back({16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
		pending_quats.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
		pending_quats.push_back({16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
		pending_quats.push_back({16'sd11585, 16'sd11585, 16'sd0, 16'sd0});
		pending_quats.push_back({16'sd11585, -16'sd11585, 16'sd0, 16'sd0});
		pending_quats.push_back({16'sd8192, 16'sd8192, 16'sd8192, -16'sd8192});
		pending_quats.push_back({-16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
		pending_quats.push_back({16'sd11586, 16'sd11585, 16'sd0, 16'sd0});
		pending_quats.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd0});
		pending_quats.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd16384});
		pending_quats.push_back({-16'sd1, 16'sd0, 16'sd1, 16'sd0});
		pending_quats.push_back({-16'sd100, 16'sd0, -16'sd1, 16'sd0});
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: ;
				1: reg_write(REG_DEGREES_MODE, 32'd1);
				2: reg_write(REG_LOCK_TOL, 32'd0);
				3: reg_write(REG_LOCK_TOL, 32'h001FFFFF);
				4: begin
					reg_write(REG_DEGREES_MODE, 32'hFFFFFFFE);
					reg_write(REG_LOCK_TOL, 32'd1048576);
				end
				5: begin
					reg_write(REG_DEGREES_MODE, 32'd1);
					reg_write(REG_LOCK_TOL, 32'hFFE00A7C);
				end
			endcase
			if (ph == 1) begin
				pending_quats.push_back({16'sd8192, 16'sd8192, 16'sh7FFF, -16'sd8192});
				pending_quats.push_back({16'sd8192, 16'sd8192, 16'sh8000, -16'sd8192});
			end
			if (ph == 5) gaps_on = 1'b0;
			load_random(250);
			if (ph == 2) begin
				// hold the stream until the pipe has emptied
				hold_stream = 1'b1;
				while (quat_valid || expected_angles.size() > 0) @(posedge clk);
				hold_stream = 1'b0;
			end
			drain();
		end
		if (mismatches == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
